// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define PFE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pfe assertion failed");

// Check that a condition never holds outside reset
`define PFE_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pfe forbidden condition seen");

`endif

// ----- sv/pfe_pkg.sv -----
package pfe_pkg;

    localparam int LETTER_W    = 5;
    localparam int CELL_W      = 5;
    localparam int NUM_CELLS   = 25;
    localparam int NUM_LETTERS = 26;

    localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X    = 5'd23;
    localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
    localparam logic [CELL_W-1:0]   FULL_COUNT  = 5'd25;

    typedef enum logic [1:0] {
        ACT_KEY      = 2'd0,
        ACT_KEY_DONE = 2'd1,
        ACT_TEXT     = 2'd2,
        ACT_TEXT_END = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_POS,
        ST_SQR,
        ST_OUT0,
        ST_OUT1
    } state_t;

    // Memory requests from the controller to the square stores
    typedef struct packed {
        logic                wr_en;
        logic [CELL_W-1:0]   wr_cell;
        logic [LETTER_W-1:0] wr_letter;
        logic [LETTER_W-1:0] pos_rd_a;
        logic [LETTER_W-1:0] pos_rd_b;
        logic [CELL_W-1:0]   sq_rd_a;
        logic [CELL_W-1:0]   sq_rd_b;
    } sq_req_t;

    // Registered read data from the square stores
    typedef struct packed {
        logic [CELL_W-1:0]   pos_a;
        logic [CELL_W-1:0]   pos_b;
        logic [LETTER_W-1:0] sq_a;
        logic [LETTER_W-1:0] sq_b;
    } sq_rsp_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_a;
        logic [CELL_W-1:0] cell_b;
    } cell_pair_t;

    function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    // Map the pad register to a legal letter: out of range acts as X, J as I
    function automatic logic [LETTER_W-1:0] pad_value(input logic [LETTER_W-1:0] p);
        logic [LETTER_W-1:0] v;
        v = (p > LAST_LETTER) ? LETTER_X : p;
        return fold_j(v);
    endfunction

    function automatic logic [2:0] cell_row(input logic [CELL_W-1:0] p);
        logic [2:0] r;
        if (p >= 5'd20)
            r = 3'd4;
        else if (p >= 5'd15)
            r = 3'd3;
        else if (p >= 5'd10)
            r = 3'd2;
        else if (p >= 5'd5)
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] row_base(input logic [2:0] r);
        return CELL_W'({r, 2'b00}) + CELL_W'(r);
    endfunction

    function automatic logic [2:0] step_wrap(input logic [2:0] v);
        return (v >= 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

    // Apply the pair rules: same column, then same row, then rectangle swap
    function automatic cell_pair_t encrypt_cells(input logic [CELL_W-1:0] pa,
                                                 input logic [CELL_W-1:0] pb);
        logic [2:0] ra;
        logic [2:0] rb;
        logic [2:0] ca;
        logic [2:0] cb;
        cell_pair_t res;
        ra = cell_row(pa);
        rb = cell_row(pb);
        ca = 3'(pa - row_base(ra));
        cb = 3'(pb - row_base(rb));
        if (ca == cb) begin
            res.cell_a = row_base(step_wrap(ra)) + CELL_W'(ca);
            res.cell_b = row_base(step_wrap(rb)) + CELL_W'(cb);
        end
        else if (ra == rb) begin
            res.cell_a = row_base(ra) + CELL_W'(step_wrap(ca));
            res.cell_b = row_base(rb) + CELL_W'(step_wrap(cb));
        end
        else begin
            res.cell_a = row_base(ra) + CELL_W'(cb);
            res.cell_b = row_base(rb) + CELL_W'(ca);
        end
        return res;
    endfunction

endpackage

// ----- sv/pfe_square.sv -----
module pfe_square
    import pfe_pkg::*;
(
    input  logic    clk,
    input  sq_req_t req,
    output sq_rsp_t rsp
);

    logic [LETTER_W-1:0] square_mem [NUM_CELLS];
    logic [CELL_W-1:0]   pos_mem    [NUM_LETTERS];

    // Write the cell and its reverse lookup together
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            square_mem[req.wr_cell] <= req.wr_letter;
            pos_mem[req.wr_letter]  <= req.wr_cell;
        end
    end

    // Read two positions and two cells each cycle into registered outputs
    always_ff @(posedge clk)
    begin
        rsp.pos_a <= pos_mem[req.pos_rd_a];
        rsp.pos_b <= pos_mem[req.pos_rd_b];
        rsp.sq_a  <= square_mem[req.sq_rd_a];
        rsp.sq_b  <= square_mem[req.sq_rd_b];
    end

endmodule

// ----- sv/playfair_cipher_encrypt.sv -----
// Playfair encryptor for letters coded A=0..Z=25. Key letters (action 0) build the 5x5
// square, key-done (action 1) completes it, text letters (action 2) are paired and each
// closed pair yields two cipher letters, the second flagged by last; text-end (action 3)
// pads an odd leftover with pad_letter. One item is in work at a time. Key letters, a
// first text letter and items that change nothing finish in their accept cycle. Key-done
// then steps through the alphabet, one letter per cycle, to fill the remaining cells through
// the square memory's single write port. An item that closes a pair reads both letter
// positions in its accept cycle; ST_POS then reads both cipher cells from the square memory,
// ST_SQR registers them, then ST_OUT0 and ST_OUT1 each hold one result until out_ready.
// Reset leaves the square memories unwritten; no text is encrypted before a key-done, so
// no clearing pass is needed.
`include "assert_macros.svh"

module playfair_cipher_encrypt
    import pfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LETTER_W-1:0] cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [LETTER_W-1:0] letter,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LETTER_W-1:0] cipher_letter,
    output logic                last
);

    state_t                 state_reg, state_next;
    logic [LETTER_W-1:0]    pad_reg;
    logic [NUM_LETTERS-1:0] used_reg, used_next;
    logic [CELL_W-1:0]      fill_reg, fill_next;
    logic                   complete_reg, complete_next;
    logic [LETTER_W-1:0]    pending_reg, pending_next;
    logic                   pending_valid_reg, pending_valid_next;
    logic [LETTER_W-1:0]    fill_idx_reg, fill_idx_next;
    logic [LETTER_W-1:0]    res0_reg, res0_next;
    logic [LETTER_W-1:0]    res1_reg, res1_next;

    sq_req_t                req;
    sq_rsp_t                rsp;
    cell_pair_t             pair;
    logic [LETTER_W-1:0]    in_letter;
    logic [LETTER_W-1:0]    pad_letter_eff;
    logic                   letter_ok;
    logic [NUM_LETTERS-1:0] used_base;
    logic [CELL_W-1:0]      fill_base;

    pfe_square u_square (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    assign in_letter      = fold_j(letter);
    assign pad_letter_eff = pad_value(pad_reg);
    assign letter_ok      = (letter <= LAST_LETTER);
    assign pair           = encrypt_cells(rsp.pos_a, rsp.pos_b);

    // A key letter on a complete square starts over from an empty square
    assign used_base = complete_reg ? '0 : used_reg;
    assign fill_base = complete_reg ? '0 : fill_reg;

    // Hold the pad register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_reg <= LETTER_X;
        else if (cfg_we)
            pad_reg <= cfg_wdata;
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            used_reg          <= '0;
            fill_reg          <= '0;
            complete_reg      <= 1'b0;
            pending_reg       <= '0;
            pending_valid_reg <= 1'b0;
            fill_idx_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            used_reg          <= used_next;
            fill_reg          <= fill_next;
            complete_reg      <= complete_next;
            pending_reg       <= pending_next;
            pending_valid_reg <= pending_valid_next;
            fill_idx_reg      <= fill_idx_next;
        end
    end

    // Hold result letters
    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    // Sequence items through the square memories
    always_comb
    begin
        state_next         = state_reg;
        used_next          = used_reg;
        fill_next          = fill_reg;
        complete_next      = complete_reg;
        pending_next       = pending_reg;
        pending_valid_next = pending_valid_reg;
        fill_idx_next      = fill_idx_reg;
        res0_next          = res0_reg;
        res1_next          = res1_reg;
        req                = '0;
        in_ready           = 1'b0;
        out_valid          = 1'b0;
        cipher_letter      = res0_reg;
        last               = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (action_t'(action))
                        ACT_KEY:
                        begin
                            if (letter_ok)
                            begin
                                used_next     = used_base;
                                fill_next     = fill_base;
                                complete_next = 1'b0;
                                if (complete_reg)
                                    pending_valid_next = 1'b0;
                                if (fill_base < FULL_COUNT && !used_base[in_letter])
                                begin
                                    req.wr_en     = 1'b1;
                                    req.wr_cell   = fill_base;
                                    req.wr_letter = in_letter;
                                    used_next     = used_base
                                                    | (NUM_LETTERS'(1) << in_letter);
                                    fill_next     = fill_base + 1'b1;
                                end
                            end
                        end
                        ACT_KEY_DONE:
                        begin
                            if (!complete_reg)
                            begin
                                fill_idx_next = '0;
                                state_next    = ST_FILL;
                            end
                        end
                        ACT_TEXT:
                        begin
                            if (letter_ok && complete_reg)
                            begin
                                if (!pending_valid_reg)
                                begin
                                    pending_next       = in_letter;
                                    pending_valid_next = 1'b1;
                                end
                                else
                                begin
                                    req.pos_rd_a = pending_reg;
                                    if (in_letter == pending_reg)
                                        req.pos_rd_b = pad_letter_eff;
                                    else
                                    begin
                                        req.pos_rd_b       = in_letter;
                                        pending_valid_next = 1'b0;
                                    end
                                    state_next = ST_POS;
                                end
                            end
                        end
                        ACT_TEXT_END:
                        begin
                            if (complete_reg && pending_valid_reg)
                            begin
                                req.pos_rd_a       = pending_reg;
                                req.pos_rd_b       = pad_letter_eff;
                                pending_valid_next = 1'b0;
                                state_next         = ST_POS;
                            end
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                // Examine one letter per cycle and place it if unused, skipping J
                if (fill_idx_reg != LETTER_J && !used_reg[fill_idx_reg]
                    && fill_reg < FULL_COUNT)
                begin
                    req.wr_en     = 1'b1;
                    req.wr_cell   = fill_reg;
                    req.wr_letter = fill_idx_reg;
                    used_next     = used_reg | (NUM_LETTERS'(1) << fill_idx_reg);
                    fill_next     = fill_reg + 1'b1;
                end
                if (fill_idx_reg == LAST_LETTER)
                begin
                    complete_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                    fill_idx_next = fill_idx_reg + 1'b1;
            end
            ST_POS:
            begin
                req.sq_rd_a = pair.cell_a;
                req.sq_rd_b = pair.cell_b;
                state_next  = ST_SQR;
            end
            ST_SQR:
            begin
                res0_next  = rsp.sq_a;
                res1_next  = rsp.sq_b;
                state_next = ST_OUT0;
            end
            ST_OUT0:
            begin
                out_valid     = 1'b1;
                cipher_letter = res0_reg;
                if (out_ready)
                    state_next = ST_OUT1;
            end
            ST_OUT1:
            begin
                out_valid     = 1'b1;
                cipher_letter = res1_reg;
                last          = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Check controller invariants
    `PFE_NEVER(a_no_accept_while_output, clk, rst_n, in_ready && out_valid)
    `PFE_ASSERT(a_pos_then_sqr, clk, rst_n, (state_reg == ST_POS) |=> (state_reg == ST_SQR))
    `PFE_ASSERT(a_complete_full, clk, rst_n, complete_reg |-> (fill_reg == FULL_COUNT))
    `PFE_ASSERT(a_complete_from_fill, clk, rst_n, $rose(complete_reg) |-> $past(state_reg == ST_FILL))

endmodule
